### rtl/assert_macros.svh
// assertion helper macros for the rtl files
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, masked while reset is asserted
`define LRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check with no reset masking, for invariants that hold through reset
`define LRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/lrt_pkg.sv
// shared types, sizes and codes for the longest prefix route table
// no dependencies; imported by lrt_cmp and the top level
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

  // table sizing
  localparam int TABLE_DEPTH = 16;
  localparam int NUM_IFACES  = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // longest legal prefix
  localparam logic [5:0] PFX_MAX = 6'd32;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ROUTE = 1'b1;

  // status codes
  localparam logic [2:0] ST_ADDED       = 3'd0;
  localparam logic [2:0] ST_FORWARDED   = 3'd1;
  localparam logic [2:0] ST_NO_ROUTE    = 3'd2;
  localparam logic [2:0] ST_TTL_EXPIRED = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;

  // input word
  typedef struct packed {
    logic        cmd;
    logic [31:0] prefix_addr;
    logic [5:0]  prefix_bits;
    logic        hop_present;
    logic [31:0] hop_addr;
    logic [2:0]  iface_index;
    logic [31:0] dest_addr;
    logic [7:0]  ttl_in;
  } lrt_in_t;

  // result word
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  out_iface;
    logic [31:0] out_hop;
    logic [7:0]  ttl_out;
  } lrt_out_t;

  // one stored route
  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  plen;
    logic        has_hop;
    logic [31:0] hop;
    logic [2:0]  iface;
  } lrt_entry_t;

  // compare unit verdict
  typedef struct packed {
    logic hit;
    logic take;
  } lrt_cmp_t;

  // interface index folded onto the configured interface count
  function automatic logic [2:0] iface_wrap(input logic [2:0] v);
    logic [2:0] r;
    case (v)
      3'd0: r = 3'(0 % NUM_IFACES);
      3'd1: r = 3'(1 % NUM_IFACES);
      3'd2: r = 3'(2 % NUM_IFACES);
      3'd3: r = 3'(3 % NUM_IFACES);
      3'd4: r = 3'(4 % NUM_IFACES);
      3'd5: r = 3'(5 % NUM_IFACES);
      3'd6: r = 3'(6 % NUM_IFACES);
      3'd7: r = 3'(7 % NUM_IFACES);
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/lrt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/lrt_cmp.sv
// shared prefix compare unit: masks one stored route against the destination
// depends on lrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrt_cmp
  import lrt_pkg::*;
(
  input  wire logic [31:0] dest,
  input  wire lrt_entry_t  entry,
  input  wire logic        found,
  input  wire logic [5:0]  best_len,
  output lrt_cmp_t         verdict
);

  logic [31:0] mask;

  // high-order mask of plen ones; zero length masks nothing so everything hits
  always_comb begin
    mask         = ~(32'hFFFF_FFFF >> entry.plen);
    verdict.hit  = ((dest ^ entry.prefix) & mask) == 32'd0;
    // strictly longer wins, so the earliest entry keeps a tie
    verdict.take = verdict.hit && (!found || (entry.plen > best_len));
  end

endmodule

`default_nettype wire

### rtl/longest_prefix_route_table.sv
// top level of the longest prefix route table: sequencer, route store and result register
// depends on lrt_pkg, lrt_ram, lrt_cmp and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// An add word's result strobes on out_valid in the cycle after the word is taken;
// busy stays low, so adds can stream every cycle. A route word walks the stored
// routes through one shared compare unit, one entry per cycle from a single RAM read
// port: busy is high from acceptance through the scan, drain and done states (done
// alone with an empty table), the result strobes in the first cycle with busy low again,
// and the next word can be started in that same cycle. Each result is shown for exactly
// one cycle with out_valid and must be captured then; there is no back-pressure on the
// result side.
module longest_prefix_route_table
  import lrt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire lrt_in_t in_word,
  output logic         out_valid,
  output lrt_out_t     out_word
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } lrt_state_t;

  lrt_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             rv_r, rv_nxt;
  logic             found_r, found_nxt;
  logic [5:0]       best_len_r, best_len_nxt;
  logic [31:0]      best_hop_r, best_hop_nxt;
  logic [2:0]       best_iface_r, best_iface_nxt;
  logic [31:0]      dest_r, dest_nxt;
  logic [7:0]       ttl_r, ttl_nxt;
  logic             out_valid_r, out_valid_nxt;
  lrt_out_t         out_word_r, out_word_nxt;

  logic             accept;
  logic             full;
  logic             ram_we;
  lrt_entry_t       wr_entry;
  lrt_entry_t       rd_entry;
  lrt_cmp_t         verdict;

  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(TABLE_DEPTH));
  assign ram_we = accept && (in_word.cmd == CMD_ADD) && !full;

  // route being added, length saturated and interface folded
  always_comb begin
    wr_entry.prefix  = in_word.prefix_addr;
    wr_entry.plen    = (in_word.prefix_bits > PFX_MAX) ? PFX_MAX : in_word.prefix_bits;
    wr_entry.has_hop = in_word.hop_present;
    wr_entry.hop     = in_word.hop_addr;
    wr_entry.iface   = iface_wrap(in_word.iface_index);
  end

  // route store
  lrt_ram #(
    .WIDTH ($bits(lrt_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (scan_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // shared compare unit
  lrt_cmp u_cmp (
    .dest     (dest_r),
    .entry    (rd_entry),
    .found    (found_r),
    .best_len (best_len_r),
    .verdict  (verdict)
  );

  // sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    rv_nxt         = 1'b0;
    found_nxt      = found_r;
    best_len_nxt   = best_len_r;
    best_hop_nxt   = best_hop_r;
    best_iface_nxt = best_iface_r;
    dest_nxt       = dest_r;
    ttl_nxt        = ttl_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;

    // fold in the entry read last cycle
    if (rv_r && verdict.take) begin
      found_nxt      = 1'b1;
      best_len_nxt   = rd_entry.plen;
      best_hop_nxt   = rd_entry.has_hop ? rd_entry.hop : dest_r;
      best_iface_nxt = rd_entry.iface;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.cmd == CMD_ADD) begin
            out_valid_nxt        = 1'b1;
            out_word_nxt         = '0;
            out_word_nxt.status  = full ? ST_FULL : ST_ADDED;
            if (!full) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            dest_nxt  = in_word.dest_addr;
            ttl_nxt   = in_word.ttl_in;
            found_nxt = 1'b0;
            scan_nxt  = '0;
            state_nxt = (count_r == '0) ? S_DONE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rv_nxt   = 1'b1;
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_nxt == count_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '0;
        if (!found_r) begin
          out_word_nxt.status = ST_NO_ROUTE;
        end else if (ttl_r <= 8'd1) begin
          out_word_nxt.status = ST_TTL_EXPIRED;
        end else begin
          out_word_nxt.status    = ST_FORWARDED;
          out_word_nxt.out_iface = best_iface_r;
          out_word_nxt.out_hop   = best_hop_r;
          out_word_nxt.ttl_out   = ttl_r - 8'd1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      rv_r        <= rv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_len_r   <= best_len_nxt;
    best_hop_r   <= best_hop_nxt;
    best_iface_r <= best_iface_nxt;
    dest_r       <= dest_nxt;
    ttl_r        <= ttl_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  `LRT_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_DEPTH), "route count beyond table depth")
  `LRT_ASSERT(a_rv_in_walk, rv_r |-> (state_r == S_SCAN || state_r == S_DRAIN), "read data outside walk")
  `LRT_ASSERT(a_strobe_src, out_valid_r |-> $past(state_r == S_DONE || ram_we || (accept && in_word.cmd == CMD_ADD)), "result strobe without a source")
  `LRT_ASSERT(a_found_nonempty, (state_r == S_DONE && found_r) |-> (count_r != '0), "match reported on empty table")
  `LRT_ASSERT(a_scan_bound, (state_r == S_SCAN) |-> (scan_r < count_r), "walk address past stored routes")

endmodule

`default_nettype wire
